@@ src/eewd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the exchange enhancement factor pipeline.
// No dependencies; imported by every module of the block.
package eewd_pkg;

    // Gradient scale K in Q0.32 (fits 30 bits)
    localparam logic [29:0] K_Q32 = 30'd550950862;

    // Polynomial coefficients and unity in Q.30
    localparam logic [33:0] ONE_Q = 34'd1073741824;
    localparam logic [33:0] T0_Q  = 34'd1074600817;
    localparam logic [33:0] T1_Q  = 34'd206802675;
    localparam logic [33:0] T2_Q  = 34'd2036029247;

    // Divider geometry: 37-bit divisor, 31 quotient bits
    localparam int DEN_W = 37;
    localparam int QUO_W = 31;

    // Internal unsigned Q.30 value
    typedef logic [33:0] t_q;

    // Control that travels with each word down the pipeline
    typedef struct packed {
        logic       valid;
        logic [1:0] ord;
    } t_ctl;

endpackage

@@ src/eewd_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: a = round(2^60 / d), one quotient bit per stage.
// Depends on eewd_pkg.
module eewd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  eewd_pkg::t_ctl              i_ctl,
    input  logic [eewd_pkg::DEN_W-1:0]  i_den,
    output eewd_pkg::t_ctl              o_ctl,
    output logic [eewd_pkg::QUO_W-1:0]  o_quo
);
    import eewd_pkg::*;

    // Per-stage registers; index k holds the word after quotient bit QUO_W-1-k
    logic [DEN_W-1:0] r_rem [0:QUO_W-1];
    logic [DEN_W-1:0] r_den [0:QUO_W-1];
    logic [QUO_W-1:0] r_low [0:QUO_W-1];
    logic [QUO_W-1:0] r_quo [0:QUO_W-1];
    t_ctl             r_ctl [0:QUO_W-1];

    // Stage inputs (previous stage or the incoming word)
    logic [DEN_W-1:0] c_rem [0:QUO_W-1];
    logic [DEN_W-1:0] c_den [0:QUO_W-1];
    logic [QUO_W-1:0] c_low [0:QUO_W-1];
    logic [QUO_W-1:0] c_quo [0:QUO_W-1];
    t_ctl             c_ctl [0:QUO_W-1];

    // Stage outputs
    logic [DEN_W-1:0] n_rem [0:QUO_W-1];
    logic [QUO_W-1:0] n_quo [0:QUO_W-1];

    // Dividend is 2^60 + d/2: top part seeds the remainder, low 31 bits shift in
    always_comb begin
        c_rem[0] = DEN_W'(1 << 29) | {{(DEN_W-5){1'b0}}, i_den[DEN_W-1:DEN_W-5]};
        c_den[0] = i_den;
        c_low[0] = i_den[QUO_W:1];
        c_quo[0] = '0;
        c_ctl[0] = i_ctl;
        for (int k = 1; k < QUO_W; k++) begin
            c_rem[k] = r_rem[k-1];
            c_den[k] = r_den[k-1];
            c_low[k] = r_low[k-1];
            c_quo[k] = r_quo[k-1];
            c_ctl[k] = r_ctl[k-1];
        end
    end

    // One compare and subtract per stage
    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            logic [DEN_W:0] trial;
            trial = {c_rem[k], c_low[k][QUO_W-1-k]};
            n_quo[k] = c_quo[k];
            if (trial >= {1'b0, c_den[k]}) begin
                n_rem[k] = DEN_W'(trial - {1'b0, c_den[k]});
                n_quo[k][QUO_W-1-k] = 1'b1;
            end else begin
                n_rem[k] = trial[DEN_W-1:0];
            end
        end
    end

    // Advance control; clear valid bits on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) r_ctl[k] <= '0;
        end else if (i_en) begin
            for (int k = 0; k < QUO_W; k++) r_ctl[k] <= c_ctl[k];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= c_den[k];
                r_low[k] <= c_low[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_ctl = r_ctl[QUO_W-1];
    assign o_quo = r_quo[QUO_W-1];

endmodule

@@ src/eewd_poly.sv @@
`timescale 1ns / 1ps
// Polynomial and derivative pipeline: from a = 1/(1+s) to F and its x-derivatives.
// Depends on eewd_pkg; seven register stages, one product per path per stage.
module eewd_poly (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  eewd_pkg::t_ctl              i_ctl,
    input  logic [eewd_pkg::QUO_W-1:0]  i_quo,
    output eewd_pkg::t_ctl              o_ctl,
    output logic signed [39:0]          o_f0,
    output logic signed [39:0]          o_f1,
    output logic signed [39:0]          o_f2,
    output logic signed [39:0]          o_f3
);
    import eewd_pkg::*;

    localparam int NSTG = 7;

    // Rounded Q.30 product
    function automatic t_q qmul(input t_q p, input t_q q);
        logic [67:0] prod;
        prod = p * q + 68'd536870912;
        return prod[63:30];
    endfunction

    // b = K*a in Q.30
    function automatic t_q kmul(input t_q a);
        logic [61:0] prod;
        prod = K_Q32 * a[QUO_W-1:0] + 62'h80000000;
        return {5'b0, prod[60:32]};
    endfunction

    // Widen to signed
    function automatic logic signed [39:0] sx(input t_q v);
        return $signed({6'b0, v});
    endfunction

    t_ctl r_ctl [0:NSTG-1];

    // Stage 0
    t_q r_p0_a, r_p0_u;
    // Stage 1
    t_q r_p1_a, r_p1_u, r_p1_b, r_p1_a2, r_p1_u2, r_p1_tu;
    // Stage 2
    t_q r_p2_a, r_p2_u, r_p2_u2, r_p2_tu, r_p2_a2, r_p2_b;
    t_q r_p2_w, r_p2_b2, r_p2_ab, r_p2_a3;
    // Stage 3
    t_q r_p3_u, r_p3_u2, r_p3_tu, r_p3_ab, r_p3_a3, r_p3_a2;
    t_q r_p3_pp, r_p3_qq, r_p3_tw, r_p3_b3, r_p3_b2a2, r_p3_b2a, r_p3_a;
    // Stage 4
    t_q r_p4_qq, r_p4_tu, r_p4_ab, r_p4_b2a2, r_p4_b2a;
    t_q r_p4_up, r_p4_ff, r_p4_b3a3, r_p4_b3a2, r_p4_b3a;
    // Stage 5
    t_q r_p5_f, r_p5_f1p, r_p5_f2a, r_p5_f2b, r_p5_f3a, r_p5_f3b, r_p5_f3c;
    // Stage 6
    logic signed [39:0] r_p6_f0, r_p6_f1, r_p6_f2, r_p6_f3;

    // Advance control; clear valid bits on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) r_ctl[k] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < NSTG; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    // Arithmetic stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // u = 1 - a
            r_p0_a <= {3'b0, i_quo};
            r_p0_u <= ONE_Q - {3'b0, i_quo};

            // b, a^2, u^2, T2*u
            r_p1_a  <= r_p0_a;
            r_p1_u  <= r_p0_u;
            r_p1_b  <= kmul(r_p0_a);
            r_p1_a2 <= qmul(r_p0_a, r_p0_a);
            r_p1_u2 <= qmul(r_p0_u, r_p0_u);
            r_p1_tu <= qmul(T2_Q, r_p0_u);

            // w, b^2, a*b, a^3
            r_p2_a  <= r_p1_a;
            r_p2_u  <= r_p1_u;
            r_p2_u2 <= r_p1_u2;
            r_p2_tu <= r_p1_tu;
            r_p2_a2 <= r_p1_a2;
            r_p2_b  <= r_p1_b;
            r_p2_w  <= qmul(T2_Q, r_p1_u2);
            r_p2_b2 <= qmul(r_p1_b, r_p1_b);
            r_p2_ab <= qmul(r_p1_a, r_p1_b);
            r_p2_a3 <= qmul(r_p1_a2, r_p1_a);

            // P, Q, T1+w, b^3 and b^2 products
            r_p3_a    <= r_p2_a;
            r_p3_a2   <= r_p2_a2;
            r_p3_u    <= r_p2_u;
            r_p3_u2   <= r_p2_u2;
            r_p3_tu   <= r_p2_tu;
            r_p3_ab   <= r_p2_ab;
            r_p3_a3   <= r_p2_a3;
            r_p3_pp   <= T1_Q + (r_p2_w << 1);
            r_p3_qq   <= T1_Q + (r_p2_w << 2) + (r_p2_w << 1);
            r_p3_tw   <= T1_Q + r_p2_w;
            r_p3_b3   <= qmul(r_p2_b2, r_p2_b);
            r_p3_b2a2 <= qmul(r_p2_b2, r_p2_a2);
            r_p3_b2a  <= qmul(r_p2_b2, r_p2_a);

            // u*P, factor product and b^3 products
            r_p4_qq   <= r_p3_qq;
            r_p4_tu   <= r_p3_tu;
            r_p4_ab   <= r_p3_ab;
            r_p4_b2a2 <= r_p3_b2a2;
            r_p4_b2a  <= r_p3_b2a;
            r_p4_up   <= qmul(r_p3_u, r_p3_pp);
            r_p4_ff   <= qmul(r_p3_u2, r_p3_tw);
            r_p4_b3a3 <= qmul(r_p3_b3, r_p3_a3);
            r_p4_b3a2 <= qmul(r_p3_b3, r_p3_a2);
            r_p4_b3a  <= qmul(r_p3_b3, r_p3_a);

            // Final products of each derivative term
            r_p5_f   <= T0_Q + r_p4_ff;
            r_p5_f1p <= qmul(r_p4_up, r_p4_ab);
            r_p5_f2a <= qmul(r_p4_qq, r_p4_b2a2);
            r_p5_f2b <= qmul(r_p4_up, r_p4_b2a);
            r_p5_f3a <= qmul(r_p4_tu, r_p4_b3a3);
            r_p5_f3b <= qmul(r_p4_qq, r_p4_b3a2);
            r_p5_f3c <= qmul(r_p4_up, r_p4_b3a);

            // Combine terms; drop derivatives above the requested order
            r_p6_f0 <= sx(r_p5_f);
            r_p6_f1 <= (r_ctl[5].ord >= 2'd1) ? (sx(r_p5_f1p) <<< 1) : '0;
            r_p6_f2 <= (r_ctl[5].ord >= 2'd2)
                     ? (sx(r_p5_f2a) <<< 1) - (sx(r_p5_f2b) <<< 2) : '0;
            r_p6_f3 <= (r_ctl[5].ord >= 2'd3)
                     ? (sx(r_p5_f3a) <<< 4) + (sx(r_p5_f3a) <<< 3)
                       - (sx(r_p5_f3b) <<< 3) - (sx(r_p5_f3b) <<< 2)
                       + (sx(r_p5_f3c) <<< 3) + (sx(r_p5_f3c) <<< 2) : '0;
        end
    end

    assign o_ctl = r_ctl[NSTG-1];
    assign o_f0  = r_p6_f0;
    assign o_f1  = r_p6_f1;
    assign o_f2  = r_p6_f2;
    assign o_f3  = r_p6_f3;

endmodule

@@ src/exchange_enhancement_with_derivatives.sv @@
`timescale 1ns / 1ps
// Top level: gradient scaling, divider, polynomial pipeline and output skid stage.
// Depends on eewd_pkg, eewd_div and eewd_poly.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------------
//  input   | i_valid | o_stall | i_grad_x, i_deriv_order
//  output  | o_valid | i_stall | o_enhance, o_first_deriv, o_second_deriv,
//          |         |         | o_third_deriv
//
// One word is accepted per cycle while o_stall is low. Each word passes through three
// scaling stages, the 31-stage divider (one quotient bit per stage), seven polynomial
// stages and the output register before its result can be taken.
// o_stall comes from the skid register only; the pipe freezes while it is full.
// Reset clears every valid bit; payload registers are not reset.
module exchange_enhancement_with_derivatives (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_grad_x,
    input  logic [1:0]         i_deriv_order,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_enhance,
    output logic signed [31:0] o_first_deriv,
    output logic signed [31:0] o_second_deriv,
    output logic signed [31:0] o_third_deriv
);
    import eewd_pkg::*;

    // Q.30 to Q4.28, rounding half away from zero, saturating
    function automatic logic [31:0] to_q28(input logic signed [39:0] v);
        logic [39:0] mag;
        logic [37:0] rnd;
        logic [31:0] res;
        mag = v[39] ? 40'(-v) : 40'(v);
        rnd = 38'((mag + 40'd2) >> 2);
        if (v[39]) begin
            if (rnd > 38'h80000000) rnd = 38'h80000000;
            res = 32'(38'd0 - rnd);
        end else begin
            res = (rnd > 38'h7FFFFFFF) ? 32'h7FFFFFFF : rnd[31:0];
        end
        return res;
    endfunction

    logic w_en;

    // Front stages
    t_ctl              r_f0_ctl, r_f1_ctl, r_f2_ctl;
    logic [31:0]       r_f0_x;
    logic [61:0]       r_f1_prod;
    logic [DEN_W-1:0]  r_f2_den;
    logic [61:0]       n_f2_sum;

    t_ctl              w_div_ctl, w_poly_ctl;
    logic [QUO_W-1:0]  w_div_quo;
    logic signed [39:0] w_f0, w_f1, w_f2, w_f3;
    logic [31:0]       w_r0, w_r1, w_r2, w_r3;
    logic              w_in_valid, w_take;

    // Output and skid registers
    logic              r_out_valid, r_skid_valid;
    logic [31:0]       r_out0, r_out1, r_out2, r_out3;
    logic [31:0]       r_skid0, r_skid1, r_skid2, r_skid3;

    assign w_en    = ~r_skid_valid;
    assign o_stall = r_skid_valid;

    // Front control: a word enters whenever the pipe moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_ctl <= '0;
            r_f1_ctl <= '0;
            r_f2_ctl <= '0;
        end else if (w_en) begin
            r_f0_ctl <= '{valid: i_valid, ord: i_deriv_order};
            r_f1_ctl <= r_f0_ctl;
            r_f2_ctl <= r_f1_ctl;
        end
    end

    // Scale x by K, then round to s and form d = 1 + s
    assign n_f2_sum = r_f1_prod + 62'd33554432;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f0_x    <= i_grad_x;
            r_f1_prod <= r_f0_x * K_Q32;
            r_f2_den  <= {1'b0, n_f2_sum[61:26]} + DEN_W'(1 << 30);
        end
    end

    eewd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_f2_ctl),
        .i_den   (r_f2_den),
        .o_ctl   (w_div_ctl),
        .o_quo   (w_div_quo)
    );

    eewd_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_div_ctl),
        .i_quo   (w_div_quo),
        .o_ctl   (w_poly_ctl),
        .o_f0    (w_f0),
        .o_f1    (w_f1),
        .o_f2    (w_f2),
        .o_f3    (w_f3)
    );

    assign w_r0 = to_q28(w_f0);
    assign w_r1 = to_q28(w_f1);
    assign w_r2 = to_q28(w_f2);
    assign w_r3 = to_q28(w_f3);

    assign w_in_valid = w_en & w_poly_ctl.valid;
    assign w_take     = r_out_valid & ~i_stall;

    // Output control: refill from skid first, park a word in skid when held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_take) begin
            r_out_valid  <= r_skid_valid | w_in_valid;
            r_skid_valid <= 1'b0;
        end else if (w_in_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out0 <= r_skid0;
                r_out1 <= r_skid1;
                r_out2 <= r_skid2;
                r_out3 <= r_skid3;
            end else begin
                r_out0 <= w_r0;
                r_out1 <= w_r1;
                r_out2 <= w_r2;
                r_out3 <= w_r3;
            end
        end else if (w_in_valid) begin
            r_skid0 <= w_r0;
            r_skid1 <= w_r1;
            r_skid2 <= w_r2;
            r_skid3 <= w_r3;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_enhance      = $signed(r_out0);
    assign o_first_deriv  = $signed(r_out1);
    assign o_second_deriv = $signed(r_out2);
    assign o_third_deriv  = $signed(r_out3);

endmodule
